// ===== hdl/pts_pkg.sv =====
// Package: shared types and constants of the task scheduler.
package pts_pkg;

  localparam int TASK_SLOTS_DEF      = 16;
  localparam int PRIORITY_LEVELS_DEF = 8;

  localparam int MODE_W  = 2;
  localparam int PRIO_W  = 3;
  localparam int DELAY_W = 32;
  localparam int SLOT_W  = 4;

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_START    = 2'd1,
    MODE_SELECT   = 2'd2,
    MODE_DELAY    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_WAIT    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY,
    FSM_OUT
  } fsm_t;

  // Per-cycle command from the sequencer to every cell.
  typedef struct packed {
    logic add;      // write the slot at add_idx with add_prio, ready, delay 0
    logic mark_run; // mark the slot at run_idx running
    logic demote;   // return the slot at dem_idx to ready if it is running
    logic set_wait; // put the slot at dem_idx into waiting with wait_ticks
    logic tick;     // count down nonzero delays
  } cell_cmd_t;

endpackage

// ===== hdl/pts_cell.sv =====
// One table slot: priority, status and delay count, with a scan-pass compare stage.
module pts_cell #(
  parameter int SLOT_IDX_W = pts_pkg::SLOT_W,
  parameter int LVL_W      = pts_pkg::PRIO_W,
  parameter int IDX        = 0
) (
  input  logic                      clk,
  input  pts_pkg::cell_cmd_t        cmd,
  input  logic [SLOT_IDX_W-1:0]     add_idx,
  input  logic [LVL_W-1:0]          add_prio,
  input  logic [SLOT_IDX_W-1:0]     run_idx,
  input  logic [SLOT_IDX_W-1:0]     dem_idx,
  input  logic [pts_pkg::DELAY_W-1:0] wait_ticks,
  input  logic                      used,
  input  logic [SLOT_IDX_W-1:0]     cur_idx,
  input  logic                      cur_prio_lt_valid,
  input  logic [LVL_W-1:0]          cur_prio,
  input  logic                      change,
  // Best candidate handed in from the previous cell.
  input  logic                      cand_in_v,
  input  logic [LVL_W-1:0]          cand_in_p,
  input  logic [SLOT_IDX_W-1:0]     cand_in_s,
  input  logic                      top_in_v,
  input  logic [LVL_W-1:0]          top_in_p,
  input  logic [SLOT_IDX_W-1:0]     top_in_s,
  output logic                      cand_out_v,
  output logic [LVL_W-1:0]          cand_out_p,
  output logic [SLOT_IDX_W-1:0]     cand_out_s,
  output logic                      top_out_v,
  output logic [LVL_W-1:0]          top_out_p,
  output logic [SLOT_IDX_W-1:0]     top_out_s,
  output logic [LVL_W-1:0]          prio_o,
  output logic [1:0]                status_o
);
  import pts_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] MY = SLOT_IDX_W'(IDX);

  logic [LVL_W-1:0]   prio_r;
  logic [1:0]         status_r;
  logic [DELAY_W-1:0] delay_r;
  logic               elig;

  assign prio_o   = prio_r;
  assign status_o = status_r;

  // Slot state updates; the delay countdown runs in the apply cycle.
  always_ff @(posedge clk) begin
    if (cmd.add && add_idx == MY) begin
      prio_r   <= add_prio;
      status_r <= ST_READY;
      delay_r  <= '0;
    end else begin
      if (cmd.set_wait && dem_idx == MY) begin
        status_r <= ST_WAIT;
        delay_r  <= wait_ticks;
      end else if (cmd.tick && used) begin
        if (cmd.mark_run && run_idx == MY) begin
          status_r <= ST_RUNNING;
        end else if (cmd.demote && dem_idx == MY && status_r == ST_RUNNING) begin
          status_r <= ST_READY;
        end
        if (delay_r != '0) begin
          delay_r <= delay_r - 1'b1;
          if (delay_r == DELAY_W'(1)) begin
            status_r <= ST_READY;
          end
        end
      end else if (cmd.mark_run && run_idx == MY) begin
        status_r <= ST_RUNNING;
      end
    end
  end

  // Eligibility of this slot for selection.
  assign elig = used && MY != cur_idx && status_r == ST_READY &&
                (change || (cur_prio_lt_valid && cur_prio < prio_r));

  // Keep the earlier slot on a priority tie: strict greater replaces.
  always_comb begin
    cand_out_v = cand_in_v;
    cand_out_p = cand_in_p;
    cand_out_s = cand_in_s;
    if (elig && (!cand_in_v || prio_r > cand_in_p)) begin
      cand_out_v = 1'b1;
      cand_out_p = prio_r;
      cand_out_s = MY;
    end
    top_out_v = top_in_v;
    top_out_p = top_in_p;
    top_out_s = top_in_s;
    if (used && (!top_in_v || prio_r > top_in_p)) begin
      top_out_v = 1'b1;
      top_out_p = prio_r;
      top_out_s = MY;
    end
  end
endmodule

// ===== hdl/pts_chain.sv =====
// Row of slot cells with a registered candidate hand-off between neighbors.
module pts_chain #(
  parameter int SLOTS      = pts_pkg::TASK_SLOTS_DEF,
  parameter int SLOT_IDX_W = pts_pkg::SLOT_W,
  parameter int LVL_W      = pts_pkg::PRIO_W
) (
  input  logic                        clk,
  input  pts_pkg::cell_cmd_t          cmd,
  input  logic [SLOT_IDX_W-1:0]       add_idx,
  input  logic [LVL_W-1:0]            add_prio,
  input  logic [SLOT_IDX_W-1:0]       run_idx,
  input  logic [SLOT_IDX_W-1:0]       dem_idx,
  input  logic [pts_pkg::DELAY_W-1:0] wait_ticks,
  input  logic [SLOT_IDX_W:0]         count,
  input  logic [SLOT_IDX_W-1:0]       cur_idx,
  input  logic                        change,
  input  logic                        scan_start,
  input  logic [SLOT_IDX_W:0]         scan_pos,
  output logic                        cand_v,
  output logic [SLOT_IDX_W-1:0]       cand_s,
  output logic                        top_v,
  output logic [SLOT_IDX_W-1:0]       top_s,
  output logic [1:0]                  cur_status
);
  import pts_pkg::*;

  logic [LVL_W-1:0]      prio_w   [SLOTS];
  logic [1:0]            status_w [SLOTS];
  logic                  cv_w [SLOTS];
  logic [LVL_W-1:0]      cp_w [SLOTS];
  logic [SLOT_IDX_W-1:0] cs_w [SLOTS];
  logic                  tv_w [SLOTS];
  logic [LVL_W-1:0]      tp_w [SLOTS];
  logic [SLOT_IDX_W-1:0] ts_w [SLOTS];
  // Hand-off registers between neighbors; stage k holds the result after cell k-1.
  logic                  cv_r [SLOTS];
  logic [LVL_W-1:0]      cp_r [SLOTS];
  logic [SLOT_IDX_W-1:0] cs_r [SLOTS];
  logic                  tv_r [SLOTS];
  logic [LVL_W-1:0]      tp_r [SLOTS];
  logic [SLOT_IDX_W-1:0] ts_r [SLOTS];
  logic [LVL_W-1:0]      cur_prio;

  assign cur_prio   = prio_w[cur_idx];
  assign cur_status = status_w[cur_idx];

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic used;
    assign used = (SLOT_IDX_W+1)'(k) < count;

    pts_cell #(.SLOT_IDX_W(SLOT_IDX_W), .LVL_W(LVL_W), .IDX(k)) u_cell (
      .clk, .cmd, .add_idx, .add_prio, .run_idx, .dem_idx, .wait_ticks,
      .used, .cur_idx, .cur_prio_lt_valid(1'b1), .cur_prio, .change,
      .cand_in_v(cv_r[k]), .cand_in_p(cp_r[k]), .cand_in_s(cs_r[k]),
      .top_in_v(tv_r[k]), .top_in_p(tp_r[k]), .top_in_s(ts_r[k]),
      .cand_out_v(cv_w[k]), .cand_out_p(cp_w[k]), .cand_out_s(cs_w[k]),
      .top_out_v(tv_w[k]), .top_out_p(tp_w[k]), .top_out_s(ts_w[k]),
      .prio_o(prio_w[k]), .status_o(status_w[k])
    );

    // Each cycle one cell folds in; stage k latches when the wave reaches it.
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (scan_start) begin
          cv_r[0] <= 1'b0;
          tv_r[0] <= 1'b0;
          cp_r[0] <= '0;
          tp_r[0] <= '0;
          cs_r[0] <= '0;
          ts_r[0] <= '0;
        end
      end
    end else begin : g_link
      always_ff @(posedge clk) begin
        if (scan_pos == (SLOT_IDX_W+1)'(k - 1)) begin
          cv_r[k] <= cv_w[k-1];
          cp_r[k] <= cp_w[k-1];
          cs_r[k] <= cs_w[k-1];
          tv_r[k] <= tv_w[k-1];
          tp_r[k] <= tp_w[k-1];
          ts_r[k] <= ts_w[k-1];
        end
      end
    end
  end

  // The tail cell's combinational result is read once the wave has passed it.
  assign cand_v = cv_w[SLOTS-1];
  assign cand_s = cs_w[SLOTS-1];
  assign top_v  = tv_w[SLOTS-1];
  assign top_s  = ts_w[SLOTS-1];
endmodule

// ===== hdl/priority_task_scheduler_core.sv =====
// Top level: fixed-priority preemptive task scheduler over a row of slot cells.
//
//  channel | ports                                        | direction
//  in      | in_valid/in_ready, in_mode, in_priority_req, in_delay_ticks | input beat
//  out     | out_valid/out_ready, out_running_slot, out_switched,
//          | out_accepted, out_assigned_slot               | result beat
//
// Each beat runs as a candidate wave that moves one cell per cycle down the slot row,
// then an apply step and an output step.
// One beat is in work at a time; a new beat is taken when the result register is free.
// Reset (rst_n low, synchronous) clears the sequencer, count and current slot;
// slot contents are undefined until registered.
// A stalled result holds in the output register until out_ready.
module priority_task_scheduler_core #(
  parameter int TASK_SLOTS      = pts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = pts_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pts_pkg::MODE_W-1:0]    in_mode,
  input  logic [pts_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic [pts_pkg::DELAY_W-1:0]   in_delay_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pts_pkg::SLOT_W-1:0]    out_running_slot,
  output logic                          out_switched,
  output logic                          out_accepted,
  output logic [pts_pkg::SLOT_W-1:0]    out_assigned_slot
);
  import pts_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LVL_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [IDX_W:0] FULL = (IDX_W+1)'(TASK_SLOTS);
  localparam logic [IDX_W:0] LAST = (IDX_W+1)'(TASK_SLOTS - 1);
  localparam logic [LVL_W:0] TOP_LVL = (LVL_W+1)'(PRIORITY_LEVELS - 1);

  fsm_t            state_r, state_nxt;
  mode_t           mode_r;
  logic [IDX_W:0]  count_r;
  logic [IDX_W-1:0] cur_r, idle_r;
  logic            idle_v_r;
  logic [IDX_W-1:0] before_r;
  logic [IDX_W:0]  pos_r;
  logic            acc_r;
  logic [IDX_W-1:0] asg_r;
  logic            change;
  logic            out_valid_r;
  logic [IDX_W-1:0] res_slot_r;
  logic            res_sw_r, res_acc_r;
  logic [IDX_W-1:0] res_asg_r;

  cell_cmd_t       cmd;
  logic [IDX_W-1:0] add_idx, run_idx;
  logic [LVL_W-1:0] add_prio;
  logic            cand_v, top_v;
  logic [IDX_W-1:0] cand_s, top_s;
  logic [1:0]      cur_status;
  logic            accept_in, can_add, scan_start;
  logic [LVL_W:0]  req_wide;

  assign accept_in = in_valid && in_ready;
  assign can_add   = count_r < FULL;
  assign req_wide  = (LVL_W+1)'(in_priority_req);

  // Requested priority saturates at the top level.
  always_comb begin
    if (req_wide > TOP_LVL) add_prio = TOP_LVL[LVL_W-1:0];
    else                    add_prio = req_wide[LVL_W-1:0];
  end
  assign add_idx = count_r[IDX_W-1:0];

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:  if (accept_in) state_nxt = FSM_SCAN;
      FSM_SCAN:  if (pos_r == LAST) state_nxt = FSM_APPLY;
      FSM_APPLY: state_nxt = FSM_OUT;
      FSM_OUT:   if (!out_valid_r || out_ready) state_nxt = FSM_IDLE;
      default:   state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FSM_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready   = state_r == FSM_IDLE && (!out_valid_r || out_ready);
  assign scan_start = accept_in;

  // Cell commands: adds and delay requests at acceptance, start and selection results in the apply cycle.
  always_comb begin
    cmd      = '0;
    run_idx  = top_s;
    unique case (state_r)
      FSM_IDLE: begin
        cmd.add = accept_in && can_add &&
                  (mode_t'(in_mode) == MODE_REGISTER || mode_t'(in_mode) == MODE_START);
        cmd.set_wait = accept_in && mode_t'(in_mode) == MODE_DELAY && count_r != '0;
      end
      FSM_APPLY: begin
        if (mode_r == MODE_START) begin
          cmd.mark_run = top_v;
          run_idx      = top_s;
        end else if ((mode_r == MODE_SELECT || mode_r == MODE_DELAY) && count_r != '0) begin
          cmd.tick     = 1'b1;
          cmd.mark_run = cand_v;
          cmd.demote   = cand_v;
          run_idx      = cand_s;
        end
      end
      default: cmd = '0;
    endcase
  end

  logic [IDX_W-1:0] dem_idx;
  assign dem_idx = cur_r;

  pts_chain #(.SLOTS(TASK_SLOTS), .SLOT_IDX_W(IDX_W), .LVL_W(LVL_W)) u_chain (
    .clk, .cmd, .add_idx,
    .add_prio(mode_t'(in_mode) == MODE_START ? '0 : add_prio),
    .run_idx, .dem_idx, .wait_ticks(in_delay_ticks), .count(count_r),
    .cur_idx(cur_r), .change(change), .scan_start,
    .scan_pos(state_r == FSM_SCAN ? pos_r : FULL),
    .cand_v, .cand_s, .top_v, .top_s, .cur_status
  );

  // Control and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cur_r    <= '0;
      idle_r   <= '0;
      idle_v_r <= 1'b0;
      pos_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (accept_in) begin
        mode_r   <= mode_t'(in_mode);
        before_r <= cur_r;
        pos_r    <= '0;
        acc_r    <= 1'b0;
        asg_r    <= '0;
        if (cmd.add) begin
          count_r <= count_r + 1'b1;
          acc_r   <= 1'b1;
          asg_r   <= add_idx;
          if (mode_t'(in_mode) == MODE_START) begin
            idle_r   <= add_idx;
            idle_v_r <= 1'b1;
          end
        end
      end
      if (state_r == FSM_SCAN) pos_r <= pos_r + 1'b1;
      if (state_r == FSM_APPLY && cmd.mark_run) cur_r <= run_idx;
      if (state_r == FSM_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
    end
  end

  // Preemption is open when the current task has stopped running or is the idle task.
  // Slot status holds still through the scan, so every cell sees the same flag.
  assign change = cur_status != ST_RUNNING || (idle_v_r && cur_r == idle_r);

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == FSM_OUT && (!out_valid_r || out_ready)) begin
      res_slot_r <= cur_r;
      res_sw_r   <= cur_r != before_r;
      res_acc_r  <= acc_r;
      res_asg_r  <= asg_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_running_slot  = SLOT_W'(res_slot_r);
  assign out_switched      = res_sw_r;
  assign out_accepted      = res_acc_r;
  assign out_assigned_slot = SLOT_W'(res_asg_r);

`ifndef SYNTHESIS
  // The table never grows beyond its slots.
  a_count: assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL)
    else $error("task count beyond table");
  // Input is only taken when the sequencer is idle.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == FSM_IDLE) else $error("input taken while busy");
  // A refused registration reports no slot.
  a_asg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_assigned_slot == '0) else $error("slot without accept");
  // The current slot only moves in the apply cycle.
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_SCAN |=> $stable(cur_r)) else $error("current slot moved in scan");
`endif
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for priority_task_scheduler_core: random task traffic checked against a predictor.
module tb;
  import pts_pkg::*;

  localparam int NSLOT = TASK_SLOTS_DEF;
  localparam int NLVL  = PRIORITY_LEVELS_DEF;

  typedef struct {
    mode_t       mode;
    logic [2:0]  prio;
    logic [31:0] ticks;
  } sched_req_t;

  typedef struct {
    logic [3:0] running;
    logic       switched;
    logic       accepted;
    logic [3:0] assigned;
  } sched_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [2:0]  in_priority_req;
  logic [31:0] in_delay_ticks;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_running_slot;
  logic        out_switched;
  logic        out_accepted;
  logic [3:0]  out_assigned_slot;

  sched_req_t  pending_reqs[$];
  sched_res_t  expected_res[$];
  int          error_count;
  logic        in_taken;
  int          burst_left;
  int          gap_left;
  int          stall_cycle;

  // Shadow copy of the task table.
  logic [2:0]  tbl_prio[NSLOT];
  status_t     tbl_status[NSLOT];
  logic [31:0] tbl_delay[NSLOT];
  int          tbl_count;
  int          cur_slot;
  int          idle_idx;
  bit          idle_known;

  priority_task_scheduler_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_priority_req  (in_priority_req),
    .in_delay_ticks   (in_delay_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_running_slot (out_running_slot),
    .out_switched     (out_switched),
    .out_accepted     (out_accepted),
    .out_assigned_slot(out_assigned_slot)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Append a task at the next free slot; refused once the table is full.
  function automatic bit table_add(input logic [2:0] prio, output int slot);
    slot = 0;
    if (tbl_count >= NSLOT) return 1'b0;
    slot = tbl_count;
    tbl_prio[slot] = prio;
    tbl_status[slot] = ST_READY;
    tbl_delay[slot] = '0;
    tbl_count++;
    return 1'b1;
  endfunction

  // One scheduling pass: pick the next task and count delays down.
  function automatic void table_select();
    int  cur;
    bit  change;
    bit  chosen;
    cur = cur_slot;
    change = (tbl_status[cur] != ST_RUNNING) || (idle_known && cur == idle_idx);
    chosen = 1'b0;
    for (int lvl = NLVL - 1; lvl >= 0; lvl--) begin
      for (int s = 0; s < tbl_count; s++) begin
        if (tbl_prio[s] == lvl) begin
          if (!chosen && s != cur && tbl_status[s] == ST_READY &&
              (change || tbl_prio[cur] < tbl_prio[s])) begin
            if (tbl_status[cur] == ST_RUNNING) tbl_status[cur] = ST_READY;
            chosen = 1'b1;
            cur_slot = s;
            tbl_status[s] = ST_RUNNING;
          end
          if (tbl_delay[s] != 0) begin
            tbl_delay[s]--;
            if (tbl_delay[s] == 0) tbl_status[s] = ST_READY;
          end
        end
      end
    end
  endfunction

  // Run the first task of the highest nonempty priority.
  function automatic void table_start();
    for (int lvl = NLVL - 1; lvl >= 0; lvl--) begin
      for (int s = 0; s < tbl_count; s++) begin
        if (tbl_prio[s] == lvl) begin
          cur_slot = s;
          tbl_status[s] = ST_RUNNING;
          return;
        end
      end
    end
  endfunction

  function automatic sched_res_t schedule_step(input sched_req_t req);
    sched_res_t r;
    int         prev;
    int         slot;
    bit         acc;
    prev = cur_slot;
    slot = 0;
    acc = 1'b0;
    case (req.mode)
      MODE_REGISTER: begin
        acc = table_add(req.prio, slot);
      end
      MODE_START: begin
        acc = table_add(3'd0, slot);
        if (acc) begin
          idle_idx = slot;
          idle_known = 1'b1;
        end
        table_start();
      end
      default: begin
        if (tbl_count > 0) begin
          if (req.mode == MODE_DELAY) begin
            tbl_delay[cur_slot] = req.ticks;
            tbl_status[cur_slot] = ST_WAIT;
          end
          table_select();
        end
      end
    endcase
    r.running = cur_slot[3:0];
    r.switched = (cur_slot != prev);
    r.accepted = acc;
    r.assigned = acc ? slot[3:0] : 4'd0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic void push_req(input mode_t m, input logic [2:0] p,
                                   input logic [31:0] t);
    sched_req_t q;
    q.mode = m;
    q.prio = p;
    q.ticks = t;
    pending_reqs.push_back(q);
  endfunction

  // Mostly short delays so tasks wake often; a few long or zero ones.
  function automatic logic [31:0] pick_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32'd0;
    if (r < 75) return $urandom_range(6, 1);
    if (r < 92) return $urandom_range(60, 7);
    return $urandom;
  endfunction

  // Predict at every accepted input beat.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      sched_req_t req;
      req.mode = mode_t'(in_mode);
      req.prio = in_priority_req;
      req.ticks = in_delay_ticks;
      expected_res.push_back(schedule_step(req));
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $display("ERROR %0t: result beat with nothing expected", $time);
        error_count++;
      end else begin
        sched_res_t e;
        e = expected_res.pop_front();
        if (out_running_slot !== e.running)
          report_mismatch("running_slot", out_running_slot, e.running);
        if (out_switched !== e.switched)
          report_mismatch("switched", out_switched, e.switched);
        if (out_accepted !== e.accepted)
          report_mismatch("accepted", out_accepted, e.accepted);
        if (out_assigned_slot !== e.assigned)
          report_mismatch("assigned_slot", out_assigned_slot, e.assigned);
      end
    end
  end

  // Input driver: bursts of beats separated by random gaps.
  always @(negedge clk) begin
    sched_req_t q;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_mode <= q.mode;
        in_priority_req <= q.prio;
        in_delay_ticks <= q.ticks;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(24, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: phases of always ready, random stalls and long stalls.
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(1);
      default: out_ready <= ((stall_cycle % 23) == 0);
    endcase
  end

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_priority_req = '0;
    in_delay_ticks = '0;
    out_ready = 1'b0;
    error_count = 0;
    burst_left = 1;
    gap_left = 0;
    stall_cycle = 0;
    tbl_count = 0;
    cur_slot = 0;
    idle_idx = 0;
    idle_known = 1'b0;

    // Directed: empty table, both priority extremes, start, delay extremes.
    push_req(MODE_SELECT, 3'd5, 32'd0);
    push_req(MODE_DELAY, 3'd2, 32'hFFFF_FFFF);
    push_req(MODE_REGISTER, 3'd0, 32'd0);
    push_req(MODE_SELECT, 3'd0, 32'd0);
    push_req(MODE_REGISTER, 3'd7, 32'hFFFF_FFFF);
    push_req(MODE_REGISTER, 3'd3, 32'd0);
    push_req(MODE_REGISTER, 3'd7, 32'd0);
    push_req(MODE_START, 3'd7, 32'd0);
    push_req(MODE_SELECT, 3'd0, 32'd0);
    push_req(MODE_DELAY, 3'd0, 32'd1);
    push_req(MODE_SELECT, 3'd0, 32'd0);
    push_req(MODE_DELAY, 3'd0, 32'd0);
    push_req(MODE_SELECT, 3'd0, 32'd0);
    push_req(MODE_DELAY, 3'd0, 32'hFFFF_FFFF);
    push_req(MODE_SELECT, 3'd0, 32'd0);
    push_req(MODE_REGISTER, 3'd5, 32'd0);
    push_req(MODE_START, 3'd0, 32'd0);
    push_req(MODE_DELAY, 3'd0, 32'd2);
    push_req(MODE_SELECT, 3'd0, 32'd0);
    push_req(MODE_SELECT, 3'd0, 32'd0);
    push_req(MODE_DELAY, 3'd0, 32'hAAAA_5555);

    // Random traffic; the table fills up early, then refusals show up too.
    for (int i = 0; i < 1930; i++) begin
      r = $urandom_range(99);
      if (r < 8)
        push_req(MODE_REGISTER, 3'($urandom_range(7)), $urandom);
      else if (r < 11)
        push_req(MODE_START, 3'($urandom_range(7)), $urandom);
      else if (r < 62)
        push_req(MODE_SELECT, 3'($urandom_range(7)), $urandom);
      else
        push_req(MODE_DELAY, 3'($urandom_range(7)), pick_ticks());
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_res.size() == 0)
      $display("priority_task_scheduler_core: match");
    else
      $display("priority_task_scheduler_core: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("priority_task_scheduler_core: mismatch");
    $finish;
  end

endmodule
